// ===== src/dafmt_pkg.sv =====
// ----------------------------------------------------------------------------
// dafmt_pkg
// Shared types, codes and constants of the decimal ASCII formatter.
// ----------------------------------------------------------------------------
package dafmt_pkg;

   localparam logic [1:0] KIND_UNSIGNED = 2'd0;
   localparam logic [1:0] KIND_SIGNED   = 2'd1;
   localparam logic [1:0] KIND_Q88      = 2'd2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;

   // decimal place index: 0 is ten thousands, 4 is units
   localparam logic [2:0] PLACE_TTHOU = 3'd0;
   localparam logic [2:0] PLACE_THOU  = 3'd1;
   localparam logic [2:0] PLACE_HUND  = 3'd2;
   localparam logic [2:0] PLACE_TENS  = 3'd3;
   localparam logic [2:0] PLACE_UNITS = 3'd4;

   localparam logic [14:0] FRAC_SCALE = 15'd100;

   typedef struct packed {
      logic        mode_q;       // Q8.8: integer part, point, two fraction digits
      logic        neg;          // leading minus
      logic [15:0] num;          // magnitude to print before any point
      logic [6:0]  frac_dig;     // (frac * 100) >> 8
      logic [2:0]  first_place;  // first nonzero decimal place of num, units if num is 0
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIGN,
      ST_DIGIT,
      ST_POINT
   } back_state_type;

   function automatic logic [16:0] place_of(input logic [2:0] idx);
      logic [16:0] val;
      unique case (idx)
         PLACE_TTHOU: val = 17'd10000;
         PLACE_THOU:  val = 17'd1000;
         PLACE_HUND:  val = 17'd100;
         PLACE_TENS:  val = 17'd10;
         default:     val = 17'd1;
      endcase
      return val;
   endfunction

endpackage

// ===== src/decimal_ascii_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// decimal_ascii_formatter_unit
// Formats 16-bit unsigned, signed or Q8.8 values as decimal ASCII text.
// ----------------------------------------------------------------------------
// Each input beat (req_tuser = kind, req_tdata = value) yields one to seven
// output beats of one ASCII character each, tlast on the final one. Integers
// print without leading zeros; negatives get a leading '-'; Q8.8 prints the
// magnitude's integer part, '.', and two digits of (frac*100)>>8. Input is
// classified on acceptance and held in a two-entry queue; the back end
// emits one character per cycle from its digit unit while the output is
// not stalled, and loads each item in its idle state before its first
// character, so it takes a new item only once the last one is done.
module decimal_ascii_formatter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // value
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // character
   output logic        rsp_tlast
);

   logic                 push_valid;
   logic                 push_ready;
   dafmt_pkg::entry_type push_entry;
   logic                 pop_valid;
   logic                 pop;
   dafmt_pkg::entry_type pop_entry;

   dafmt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   dafmt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   dafmt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== src/dafmt_queue.sv =====
// ----------------------------------------------------------------------------
// dafmt_queue
// Two-entry queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module dafmt_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  dafmt_pkg::entry_type  push_entry,
   output logic                  pop_valid,
   input  logic                  pop,
   output dafmt_pkg::entry_type  pop_entry
);

   dafmt_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/dafmt_front.sv =====
// ----------------------------------------------------------------------------
// dafmt_front
// Takes input beats, resolves sign and magnitude, splits Q8.8 values and
// finds the first decimal place to print.
// ----------------------------------------------------------------------------
module dafmt_front (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   output logic                  push_valid,
   input  logic                  push_ready,
   output dafmt_pkg::entry_type  push_entry
);

   logic        sign_bit;
   logic [15:0] negated;
   logic [15:0] mag;
   logic [14:0] frac_prod;
   logic [15:0] num;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign sign_bit   = req_tdata[15];
   assign negated    = 16'(~req_tdata + 16'd1);
   assign mag        = sign_bit ? negated : req_tdata;
   assign frac_prod  = 15'(mag[7:0]) * dafmt_pkg::FRAC_SCALE;

   always_comb begin
      push_entry = '0;
      num        = req_tdata;
      unique case (req_tuser)
         dafmt_pkg::KIND_SIGNED: begin
            push_entry.neg = sign_bit;
            num            = mag;
         end
         dafmt_pkg::KIND_Q88: begin
            push_entry.mode_q   = 1'b1;
            push_entry.neg      = sign_bit;
            push_entry.frac_dig = frac_prod[14:8];
            num                 = {8'd0, mag[15:8]};
         end
         default: begin
            num = req_tdata;
         end
      endcase
      push_entry.num = num;
      if (num >= 16'd10000) begin
         push_entry.first_place = dafmt_pkg::PLACE_TTHOU;
      end else if (num >= 16'd1000) begin
         push_entry.first_place = dafmt_pkg::PLACE_THOU;
      end else if (num >= 16'd100) begin
         push_entry.first_place = dafmt_pkg::PLACE_HUND;
      end else if (num >= 16'd10) begin
         push_entry.first_place = dafmt_pkg::PLACE_TENS;
      end else begin
         push_entry.first_place = dafmt_pkg::PLACE_UNITS;
      end
   end

endmodule

// ===== src/dafmt_back.sv =====
// ----------------------------------------------------------------------------
// dafmt_back
// Sequencer that emits one character beat per cycle while the output is not
// stalled: sign, one decimal digit per place, point and fraction digits.
// ----------------------------------------------------------------------------
module dafmt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop,
   input  dafmt_pkg::entry_type  pop_entry,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // character
   output logic                  rsp_tlast
);

   dafmt_pkg::back_state_type state_ff, state_in;

   logic [15:0] n_ff, n_in;
   logic [2:0]  place_ff, place_in;
   logic        mode_q_ff, mode_q_in;
   logic        frac_ph_ff, frac_ph_in;
   logic [6:0]  frac_dig_ff, frac_dig_in;
   logic        valid_ff, valid_in;
   logic [7:0]  char_ff, char_in;
   logic        last_ff, last_in;

   logic        out_free;
   logic [16:0] place_val;
   logic [3:0]  digit;
   logic [16:0] rem;

   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;
   assign place_val  = dafmt_pkg::place_of(place_ff);

   // digit at the current place; n stays below ten times the place
   always_comb begin
      digit = 4'd0;
      rem   = {1'b0, n_ff};
      for (int k = 1; k < 10; k++) begin
         if ({1'b0, n_ff} >= place_val * 17'(k)) begin
            digit = 4'(k);
            rem   = {1'b0, n_ff} - place_val * 17'(k);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      place_in    = place_ff;
      mode_q_in   = mode_q_ff;
      frac_ph_in  = frac_ph_ff;
      frac_dig_in = frac_dig_ff;
      pop         = 1'b0;
      valid_in    = valid_ff && !rsp_tready;
      char_in     = char_ff;
      last_in     = last_ff;
      unique case (state_ff)
         dafmt_pkg::ST_IDLE: begin
            if (pop_valid) begin
               pop         = 1'b1;
               n_in        = pop_entry.num;
               place_in    = pop_entry.first_place;
               mode_q_in   = pop_entry.mode_q;
               frac_ph_in  = 1'b0;
               frac_dig_in = pop_entry.frac_dig;
               state_in    = pop_entry.neg ? dafmt_pkg::ST_SIGN : dafmt_pkg::ST_DIGIT;
            end
         end
         dafmt_pkg::ST_SIGN: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = dafmt_pkg::CHAR_MINUS;
               last_in  = 1'b0;
               state_in = dafmt_pkg::ST_DIGIT;
            end
         end
         dafmt_pkg::ST_DIGIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = dafmt_pkg::CHAR_ZERO + 8'(digit);
               n_in     = rem[15:0];
               last_in  = 1'b0;
               if (place_ff == dafmt_pkg::PLACE_UNITS) begin
                  if (mode_q_ff && !frac_ph_ff) begin
                     state_in = dafmt_pkg::ST_POINT;
                  end else begin
                     last_in  = 1'b1;
                     state_in = dafmt_pkg::ST_IDLE;
                  end
               end else begin
                  place_in = place_ff + 3'd1;
               end
            end
         end
         dafmt_pkg::ST_POINT: begin
            if (out_free) begin
               valid_in   = 1'b1;
               char_in    = dafmt_pkg::CHAR_POINT;
               last_in    = 1'b0;
               n_in       = {9'd0, frac_dig_ff};
               place_in   = dafmt_pkg::PLACE_TENS;
               frac_ph_in = 1'b1;
               state_in   = dafmt_pkg::ST_DIGIT;
            end
         end
         default: begin
            state_in = dafmt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dafmt_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      place_ff    <= place_in;
      mode_q_ff   <= mode_q_in;
      frac_ph_ff  <= frac_ph_in;
      frac_dig_ff <= frac_dig_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
   end

endmodule

// ===== src/dafmt_checker.sv =====
// ----------------------------------------------------------------------------
// dafmt_checker
// Port-level checks of the formatter's output stream.
// ----------------------------------------------------------------------------
module dafmt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   logic is_digit;

   assign is_digit = (rsp_tdata >= dafmt_pkg::CHAR_ZERO) &&
                     (rsp_tdata <= dafmt_pkg::CHAR_ZERO + 8'd9);

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> is_digit || rsp_tdata == dafmt_pkg::CHAR_MINUS ||
                     rsp_tdata == dafmt_pkg::CHAR_POINT)
      else $error("illegal character");

   a_last_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> is_digit)
      else $error("text ends in a non-digit");

   a_minus_first: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_tvalid && rsp_tready && !rsp_tlast) && rsp_tvalid |->
         rsp_tdata != dafmt_pkg::CHAR_MINUS)
      else $error("minus inside a text");

endmodule

bind decimal_ascii_formatter_unit dafmt_checker u_dafmt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== test/decimal_ascii_formatter_unit_test.sv =====
// ----------------------------------------------------------------------------
// decimal_ascii_formatter_unit_test
// Self-checking bench for the decimal ASCII formatter.
// ----------------------------------------------------------------------------
// Feeds unsigned, signed, Q8.8 and spare-kind values through the request
// stream. Each accepted value is turned into its expected characters by a
// local text predictor. Every character beat on the response stream is
// checked, including tlast, against the oldest expected character. The run
// starts with directed corner values and follows with random ones. Both
// sides take random idle bursts, and the receiver makes one long hold-off.
// ----------------------------------------------------------------------------
module decimal_ascii_formatter_unit_test;

   localparam logic [1:0] KIND_SPARE  = 2'd3;   // formatted as unsigned
   localparam int         RANDOM_VALUES = 350;
   localparam int         QUIET_TAIL  = 60;
   localparam int         HOLD_CYCLES = 100;
   localparam int         HOLD_AFTER  = 150;
   localparam int         STALL_LIMIT = 2000;
   localparam int         DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] value;
   } value_item_type;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } char_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // value
   logic [1:0]  req_tuser = '0;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // character
   logic        rsp_tlast;

   value_item_type pending_values [$];
   char_beat_type  expected_chars [$];

   int  total_values    = 0;
   int  values_accepted = 0;
   int  chars_checked   = 0;
   int  error_count     = 0;
   int  kind_count [4]  = '{0, 0, 0, 0};
   int  idle_cycles     = 0;
   int  req_gap         = 0;
   int  rsp_gap         = 0;
   int  hold_left       = 0;
   bit  hold_done       = 1'b0;
   bit  req_beat_taken  = 1'b0;

   decimal_ascii_formatter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void append_decimal(input int unsigned n);
      int unsigned digits [$];
      do begin
         digits.push_front(n % 10);
         n = n / 10;
      end while (n != 0);
      foreach (digits[i]) begin
         expected_chars.push_back('{dafmt_pkg::CHAR_ZERO + 8'(digits[i]), 1'b0});
      end
   endfunction

   function automatic void predict_text(input value_item_type item);
      logic        neg;
      int unsigned mag;
      int unsigned hundredths;
      neg = (item.kind inside {dafmt_pkg::KIND_SIGNED, dafmt_pkg::KIND_Q88}) &&
            item.value[15];
      mag = neg ? 32'h10000 - item.value : item.value;
      if (neg) expected_chars.push_back('{dafmt_pkg::CHAR_MINUS, 1'b0});
      if (item.kind == dafmt_pkg::KIND_Q88) begin
         hundredths = ((mag & 32'hFF) * 100) >> 8;
         append_decimal(mag >> 8);
         expected_chars.push_back('{dafmt_pkg::CHAR_POINT, 1'b0});
         expected_chars.push_back('{dafmt_pkg::CHAR_ZERO + 8'(hundredths / 10), 1'b0});
         expected_chars.push_back('{dafmt_pkg::CHAR_ZERO + 8'(hundredths % 10), 1'b0});
      end else begin
         append_decimal(mag);
      end
      expected_chars[expected_chars.size() - 1].last = 1'b1;
   endfunction

   task automatic add_value(input logic [1:0] kind, input logic [15:0] value);
      pending_values.push_back('{kind, value});
   endtask

   function automatic bit quiet_phase();
      return values_accepted + QUIET_TAIL >= total_values;
   endfunction

   function automatic bit calm_stretch();
      return (values_accepted / 64) % 3 == 1;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_beat_taken) begin
         // beat still on offer
      end else if (req_gap > 0) begin
         req_tvalid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_values.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (!quiet_phase() && !calm_stretch() && hold_left == 0 &&
                   $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         req_gap <= $urandom_range(0, 18);
      end else begin
         req_tvalid <= 1'b1;
         req_tuser <= pending_values[0].kind;
         req_tdata <= pending_values[0].value;
      end
   end

   // response receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && chars_checked >= HOLD_AFTER) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if (!quiet_phase() && !calm_stretch() && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap <= $urandom_range(0, 18);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      char_beat_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected beat, actual char %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== want.code) begin
                  $display("%0t: char mismatch, expected %h actual %h",
                           $time, want.code, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: tlast mismatch, expected %b actual %b",
                           $time, want.last, rsp_tlast);
                  error_count++;
               end
               chars_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            predict_text('{req_tuser, req_tdata});
            kind_count[req_tuser]++;
            values_accepted++;
            void'(pending_values.pop_front());
         end
      end
      req_beat_taken <= !reset && req_tvalid && req_tready;
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog, no beat for %0d cycles", $time, STALL_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [1:0]  kind;
      logic [15:0] value;

      add_value(dafmt_pkg::KIND_UNSIGNED, 16'd0);
      add_value(dafmt_pkg::KIND_UNSIGNED, 16'hFFFF);
      add_value(dafmt_pkg::KIND_UNSIGNED, 16'd9);
      add_value(dafmt_pkg::KIND_UNSIGNED, 16'd10);
      add_value(dafmt_pkg::KIND_UNSIGNED, 16'd10000);
      add_value(dafmt_pkg::KIND_UNSIGNED, 16'h8000);
      add_value(dafmt_pkg::KIND_SIGNED, 16'd0);
      add_value(dafmt_pkg::KIND_SIGNED, 16'd5);
      add_value(dafmt_pkg::KIND_SIGNED, 16'h7FFF);
      add_value(dafmt_pkg::KIND_SIGNED, 16'h8000);
      add_value(dafmt_pkg::KIND_SIGNED, 16'hFFFF);
      add_value(dafmt_pkg::KIND_SIGNED, 16'hD8F0);
      add_value(dafmt_pkg::KIND_Q88, 16'h0000);
      add_value(dafmt_pkg::KIND_Q88, 16'h7FFF);
      add_value(dafmt_pkg::KIND_Q88, 16'h8000);
      add_value(dafmt_pkg::KIND_Q88, 16'hFFFF);
      add_value(dafmt_pkg::KIND_Q88, 16'hFE80);
      add_value(dafmt_pkg::KIND_Q88, 16'hFF80);
      add_value(dafmt_pkg::KIND_Q88, 16'h0100);
      add_value(dafmt_pkg::KIND_Q88, 16'h00FF);
      add_value(dafmt_pkg::KIND_Q88, 16'h0A40);
      add_value(KIND_SPARE, 16'h0000);
      add_value(KIND_SPARE, 16'hFFFF);
      add_value(KIND_SPARE, 16'h1234);

      for (int i = 0; i < RANDOM_VALUES; i++) begin
         case ($urandom_range(0, 9))
            0:       kind = KIND_SPARE;
            1, 2, 3: kind = dafmt_pkg::KIND_UNSIGNED;
            4, 5, 6: kind = dafmt_pkg::KIND_SIGNED;
            default: kind = dafmt_pkg::KIND_Q88;
         endcase
         case ($urandom_range(0, 5))
            0:       value = 16'($urandom_range(0, 20));
            1:       value = 16'h0000 - 16'($urandom_range(1, 300));
            2:       value = 16'h8000 ^ 16'($urandom_range(0, 255));
            3:       value = 16'($urandom_range(0, 1023));
            default: value = 16'($urandom);
         endcase
         add_value(kind, value);
      end
      total_values = pending_values.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_values.size() != 0 || expected_chars.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("values: %0d unsigned, %0d signed, %0d q8.8, %0d spare kind",
               kind_count[dafmt_pkg::KIND_UNSIGNED], kind_count[dafmt_pkg::KIND_SIGNED],
               kind_count[dafmt_pkg::KIND_Q88], kind_count[KIND_SPARE]);
      $display("characters checked: %0d, mismatches: %0d", chars_checked, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/dafmt_pkg.sv
src/dafmt_queue.sv
src/dafmt_front.sv
src/dafmt_back.sv
src/decimal_ascii_formatter_unit.sv
src/dafmt_checker.sv
test/decimal_ascii_formatter_unit_test.sv
